### hdl/iehw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iehw_pkg
// Types, next header codes and the header classifier of the IPv6
// extension header walker.
// ----------------------------------------------------------------------------
package iehw_pkg;

   localparam int FIXED_HEADER_BYTES = 40;
   localparam int NH_BYTE_INDEX      = 6;

   localparam logic [3:0] HOP_LIMIT_RESET = 4'd8;

   localparam logic [7:0] NH_HOP_BY_HOP = 8'd0;
   localparam logic [7:0] NH_ICMP       = 8'd1;
   localparam logic [7:0] NH_TCP        = 8'd6;
   localparam logic [7:0] NH_UDP        = 8'd17;
   localparam logic [7:0] NH_ROUTING    = 8'd43;
   localparam logic [7:0] NH_AH         = 8'd51;
   localparam logic [7:0] NH_ICMPV6     = 8'd58;
   localparam logic [7:0] NH_NO_NEXT    = 8'd59;
   localparam logic [7:0] NH_DEST_OPTS  = 8'd60;

   typedef enum logic [1:0] {
      NH_WALK  = 2'b00,
      NH_UPPER = 2'b01,
      NH_STOP  = 2'b10
   } nh_class_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
   } beat_type;

   typedef struct packed {
      logic        transport_found;
      logic [7:0]  protocol;
      logic [15:0] payload_offset;
      logic        length_overflow;
   } result_type;

   function automatic nh_class_type nh_classify(input logic [7:0] nh,
                                                input logic [3:0] hops,
                                                input logic [3:0] limit);
      nh_class_type cls;
      case (nh) inside
         NH_TCP, NH_UDP, NH_ICMP, NH_ICMPV6: begin
            cls = NH_UPPER;
         end
         NH_HOP_BY_HOP, NH_ROUTING, NH_DEST_OPTS, NH_AH: begin
            cls = (hops < limit) ? NH_WALK : NH_STOP;
         end
         default: begin
            cls = NH_STOP;
         end
      endcase
      return cls;
   endfunction

endpackage

### hdl/iehw_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iehw_in_reg
// Input register: holds one packet beat until the walker takes it.
// ----------------------------------------------------------------------------
module iehw_in_reg
   import iehw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [7:0] req_data_byte,
   input  logic       req_last,
   output logic       req_stall,
   input  logic       beat_take,
   output logic       beat_valid,
   output beat_type   beat
);

   logic     valid_ff;
   logic     valid_in;
   beat_type beat_ff;
   logic     load;

   assign req_stall = valid_ff & ~beat_take;
   assign load      = req_valid & ~req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (beat_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         beat_ff.data_byte <= req_data_byte;
         beat_ff.last      <= req_last;
      end
   end

   assign beat_valid = valid_ff;
   assign beat       = beat_ff;

endmodule

### hdl/iehw_walk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iehw_walk
// Per-byte walk of the extension header chain and the hop limit register.
// ----------------------------------------------------------------------------
module iehw_walk
   import iehw_pkg::*;
#(
   parameter int OFFSET_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [3:0] csr_write_data,
   input  logic       beat_valid,
   input  beat_type   beat,
   input  logic       out_free,
   output logic       beat_take,
   output logic       res_load,
   output result_type res
);

   localparam int OB = OFFSET_BITS;
   localparam logic [OB-1:0] MAX_OFF   = '1;
   localparam logic [OB-1:0] FIXED_OFF = OB'(FIXED_HEADER_BYTES);
   localparam logic [OB-1:0] NH_OFF    = OB'(NH_BYTE_INDEX);

   logic [3:0]    hop_limit_ff;
   logic [OB-1:0] byte_pos_ff, byte_pos_in;
   logic [OB-1:0] hdr_start_ff, hdr_start_in;
   logic [OB:0]   hdr_end_ff, hdr_end_in;
   logic [7:0]    cur_ff, cur_in;
   logic [7:0]    pend_ff, pend_in;
   logic [3:0]    hop_ff, hop_in;
   logic          stop_ff, stop_in;
   logic          found_ff, found_in;
   logic          ovf_ff, ovf_in;

   logic [OB-1:0] off_sel;
   logic [OB:0]   idx_p1;
   logic [OB:0]   start_p1;
   logic [11:0]   adv;
   nh_class_type  cls_here;

   assign beat_take = beat_valid & (~beat.last | out_free);
   assign res_load  = beat_take & beat.last;
   assign idx_p1    = {1'b0, byte_pos_ff} + 1'b1;
   assign start_p1  = {1'b0, hdr_start_ff} + 1'b1;
   assign cls_here  = nh_classify(cur_ff, hop_ff, hop_limit_ff);

   // AH spans (len+2)*4, the others (len+1)*8
   always_comb begin
      if (cur_ff == NH_AH) begin
         adv = {1'b0, 9'({1'b0, beat.data_byte} + 9'd2), 2'b00};
      end else begin
         adv = {9'({1'b0, beat.data_byte} + 9'd1), 3'b000};
      end
   end

   always_comb begin
      byte_pos_in  = byte_pos_ff;
      hdr_start_in = hdr_start_ff;
      hdr_end_in   = hdr_end_ff;
      cur_in       = cur_ff;
      pend_in      = pend_ff;
      hop_in       = hop_ff;
      stop_in      = stop_ff;
      found_in     = found_ff;
      ovf_in       = ovf_ff;
      if (!ovf_ff && byte_pos_ff == MAX_OFF) begin
         ovf_in = 1'b1;
      end else if (!ovf_ff) begin
         if (byte_pos_ff == NH_OFF) begin
            cur_in = beat.data_byte;
         end
         if (!stop_ff && byte_pos_ff >= FIXED_OFF) begin
            if (byte_pos_ff == hdr_start_ff) begin
               if (cls_here != NH_WALK) begin
                  stop_in  = 1'b1;
                  found_in = (cls_here == NH_UPPER);
               end else begin
                  pend_in = beat.data_byte;
               end
            end else if ({1'b0, byte_pos_ff} == start_p1) begin
               hdr_end_in = {1'b0, hdr_start_ff} + (OB + 1)'(adv);
            end
            // last byte of the header being crossed
            if (!stop_in && byte_pos_ff != hdr_start_ff && idx_p1 == hdr_end_ff) begin
               hdr_start_in = hdr_end_ff[OB-1:0];
               cur_in       = pend_ff;
               hop_in       = hop_ff + 4'd1;
               hdr_end_in   = '0;
            end
         end
         byte_pos_in = idx_p1[OB-1:0];
      end
   end

   // result for a packet that ends on this beat
   always_comb begin
      res.length_overflow = ovf_in;
      res.transport_found = 1'b0;
      res.protocol        = cur_in;
      off_sel             = hdr_start_in;
      if (byte_pos_in < FIXED_OFF) begin
         res.protocol = NH_NO_NEXT;
         off_sel      = byte_pos_in;
      end else if (stop_in) begin
         res.transport_found = found_in;
      end else if (hdr_start_in == byte_pos_in) begin
         res.transport_found = (nh_classify(cur_in, hop_in, hop_limit_ff) == NH_UPPER);
      end
      res.payload_offset = 16'(off_sel);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hop_limit_ff <= HOP_LIMIT_RESET;
      end else if (csr_write_enable) begin
         hop_limit_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || res_load) begin
         byte_pos_ff  <= '0;
         hdr_start_ff <= FIXED_OFF;
         hdr_end_ff   <= '0;
         cur_ff       <= '0;
         pend_ff      <= '0;
         hop_ff       <= '0;
         stop_ff      <= 1'b0;
         found_ff     <= 1'b0;
         ovf_ff       <= 1'b0;
      end else if (beat_take) begin
         byte_pos_ff  <= byte_pos_in;
         hdr_start_ff <= hdr_start_in;
         hdr_end_ff   <= hdr_end_in;
         cur_ff       <= cur_in;
         pend_ff      <= pend_in;
         hop_ff       <= hop_in;
         stop_ff      <= stop_in;
         found_ff     <= found_in;
         ovf_ff       <= ovf_in;
      end
   end

   a_start_floor: assert property (@(posedge clock) disable iff (reset)
      hdr_start_ff >= FIXED_OFF)
      else $error("header start below fixed header");

   a_end_ahead: assert property (@(posedge clock) disable iff (reset)
      hdr_end_ff == '0 || hdr_end_ff > {1'b0, hdr_start_ff})
      else $error("header end not past header start");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      res_load |=> (byte_pos_ff == '0 && !stop_ff && !ovf_ff))
      else $error("packet state not cleared after last beat");

   a_ovf_pos: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> byte_pos_ff == MAX_OFF)
      else $error("overflow without full length");

endmodule

### hdl/iehw_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iehw_out_reg
// Result register: holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module iehw_out_reg
   import iehw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        res_load,
   input  result_type  res,
   output logic        out_free,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_transport_found,
   output logic [7:0]  rsp_protocol,
   output logic [15:0] rsp_payload_offset,
   output logic        rsp_length_overflow
);

   logic       valid_ff;
   logic       valid_in;
   result_type res_ff;

   assign out_free = ~valid_ff | ~rsp_stall;

   always_comb begin
      valid_in = valid_ff & rsp_stall;
      if (res_load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         res_ff <= res;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_transport_found = res_ff.transport_found;
   assign rsp_protocol        = res_ff.protocol;
   assign rsp_payload_offset  = res_ff.payload_offset;
   assign rsp_length_overflow = res_ff.length_overflow;

endmodule

### hdl/ipv6_ext_header_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv6_ext_header_walker
// Walks the IPv6 extension header chain of a byte stream, one result per packet.
// Throughput: one byte beat per cycle, set by the single-pass per-byte walk update,
// as long as a result held by rsp_stall does not keep a packet's last beat waiting.
// The last beat of a packet waits in the input register until the result register
// is free, then its result loads into the result register and rsp_valid rises.
// Reset: synchronous, clears walk state and both valid flags; hop_limit goes to 8.
module ipv6_ext_header_walker
   import iehw_pkg::*;
#(
   parameter int OFFSET_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [3:0]  csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_transport_found,
   output logic [7:0]  rsp_protocol,
   output logic [15:0] rsp_payload_offset,
   output logic        rsp_length_overflow
);

   beat_type   beat;
   logic       beat_valid;
   logic       beat_take;
   logic       res_load;
   logic       out_free;
   result_type res;

   iehw_in_reg u_in_reg (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_data_byte (req_data_byte),
      .req_last      (req_last),
      .req_stall     (req_stall),
      .beat_take     (beat_take),
      .beat_valid    (beat_valid),
      .beat          (beat)
   );

   iehw_walk #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_walk (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .beat_valid       (beat_valid),
      .beat             (beat),
      .out_free         (out_free),
      .beat_take        (beat_take),
      .res_load         (res_load),
      .res              (res)
   );

   iehw_out_reg u_out_reg (
      .clock               (clock),
      .reset               (reset),
      .res_load            (res_load),
      .res                 (res),
      .out_free            (out_free),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_transport_found (rsp_transport_found),
      .rsp_protocol        (rsp_protocol),
      .rsp_payload_offset  (rsp_payload_offset),
      .rsp_length_overflow (rsp_length_overflow)
   );

endmodule

### verif/tb_ipv6_ext_header_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ipv6_ext_header_walker
// Feeds whole IPv6 packets into the walker one byte beat at a time. A local
// copy of the chain walk predicts the single result of every packet, and each
// result beat is compared field by field with the oldest prediction. A short
// directed set of packets comes first, then random well-formed chains,
// truncated chains, noise and short packets under several hop limits, and one
// packet longer than 64 KiB. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_ipv6_ext_header_walker
   import iehw_pkg::*;
();

   localparam logic [7:0] NH_FRAGMENT    = 8'd44;
   localparam logic [7:0] NH_ESP         = 8'd50;
   localparam logic [7:0] NH_UNKNOWN     = 8'd255;
   localparam int unsigned MAX_POSITION  = 65535;
   localparam int SETTLE_CYCLES          = 8;
   localparam int MAX_IDLE_DRAW          = 12;
   localparam int WATCHDOG_LIMIT         = 3000;
   localparam int OVERSIZE_BYTES         = 65540;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [3:0]  csr_write_data = 4'd0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_transport_found;
   logic [7:0]  rsp_protocol;
   logic [15:0] rsp_payload_offset;
   logic        rsp_length_overflow;

   ipv6_ext_header_walker dut (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_data_byte       (req_data_byte),
      .req_last            (req_last),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_transport_found (rsp_transport_found),
      .rsp_protocol        (rsp_protocol),
      .rsp_payload_offset  (rsp_payload_offset),
      .rsp_length_overflow (rsp_length_overflow)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // walk state of the packet in flight
   logic [3:0]       hop_limit_cfg = HOP_LIMIT_RESET;
   int unsigned      pkt_pos;
   int unsigned      hdr_start;
   logic [7:0]       hdr_type;
   logic [7:0]       hdr_follow;
   logic [3:0]       hops_done;
   logic             chain_halted;
   logic             halt_upper;
   logic             too_long;
   longint unsigned  hdr_end;

   result_type walk_results [$];
   beat_type   beat_q [$];
   logic [7:0] pkt_bytes [$];
   logic [7:0] chain_kinds [$];

   int  mismatches = 0;
   int  results_checked = 0;
   int  bytes_sent = 0;
   int  packets_sent = 0;
   int  quiet_cycles = 0;
   int  send_gap = 0;
   int  recv_wait = 0;
   logic send_burst = 1'b0;
   logic recv_burst = 1'b0;
   logic steady_send = 1'b0;
   beat_type next_beat;
   result_type want;

   function automatic nh_class_type nh_verdict(input logic [7:0] nh);
      if (nh == NH_TCP || nh == NH_UDP || nh == NH_ICMP || nh == NH_ICMPV6)
         return NH_UPPER;
      if (nh == NH_HOP_BY_HOP || nh == NH_ROUTING || nh == NH_DEST_OPTS || nh == NH_AH)
         return (hops_done < hop_limit_cfg) ? NH_WALK : NH_STOP;
      return NH_STOP;
   endfunction

   task automatic restart_walk();
      pkt_pos = 0;
      hdr_start = FIXED_HEADER_BYTES;
      hdr_type = 8'd0;
      hdr_follow = 8'd0;
      hops_done = 4'd0;
      chain_halted = 1'b0;
      halt_upper = 1'b0;
      too_long = 1'b0;
      hdr_end = 0;
   endtask

   task automatic walk_byte(input logic [7:0] b, input logic is_last);
      int unsigned     idx;
      int unsigned     len;
      nh_class_type    verdict;
      longint unsigned span;
      result_type      r;
      idx = pkt_pos;
      if (!too_long && idx >= MAX_POSITION) begin
         too_long = 1'b1;
      end else if (!too_long) begin
         if (idx == NH_BYTE_INDEX)
            hdr_type = b;
         if (!chain_halted && idx >= FIXED_HEADER_BYTES) begin
            if (idx == hdr_start) begin
               verdict = nh_verdict(hdr_type);
               if (verdict != NH_WALK) begin
                  chain_halted = 1'b1;
                  halt_upper = (verdict == NH_UPPER);
               end else begin
                  hdr_follow = b;
               end
            end else if (idx == hdr_start + 1) begin
               // AH counts 32-bit words minus two, the rest 8-byte units minus one
               span = (hdr_type == NH_AH) ? (longint'(b) + 2) * 4 : (longint'(b) + 1) * 8;
               hdr_end = 64'(hdr_start) + span;
            end
            if (!chain_halted && idx != hdr_start && 64'(idx) + 64'd1 == hdr_end) begin
               hdr_start = 32'(hdr_end);
               hdr_type = hdr_follow;
               hops_done = hops_done + 4'd1;
               hdr_end = 0;
            end
         end
         pkt_pos = idx + 1;
      end
      if (is_last) begin
         len = pkt_pos;
         r.length_overflow = too_long;
         r.transport_found = 1'b0;
         if (len < FIXED_HEADER_BYTES) begin
            r.protocol = NH_NO_NEXT;
            r.payload_offset = 16'(len);
         end else begin
            r.protocol = hdr_type;
            r.payload_offset = 16'(hdr_start);
            if (chain_halted)
               r.transport_found = halt_upper;
            else if (hdr_start == len)
               r.transport_found = (nh_verdict(hdr_type) == NH_UPPER);
         end
         walk_results.push_back(r);
         restart_walk();
      end
   endtask

   task automatic check_field(input string what, input int unsigned exp_val,
                              input int unsigned got_val);
      if (exp_val != got_val) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_val, got_val);
      end
   endtask

   // sender: a beat stays put while stalled, then a drawn gap follows it
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_valid && !req_stall)
            walk_byte(req_data_byte, req_last);
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (beat_q.size() > 0) begin
               next_beat = beat_q.pop_front();
               req_valid <= 1'b1;
               req_data_byte <= next_beat.data_byte;
               req_last <= next_beat.last;
               send_gap <= (send_burst || steady_send) ? 0 : $urandom_range(0, MAX_IDLE_DRAW);
               if ($urandom_range(0, 39) == 0)
                  send_burst <= !send_burst;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: each result beat is held off for a drawn number of cycles
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            if (walk_results.size() == 0) begin
               mismatches++;
               $display("%0t: result beat with none expected, protocol %0d offset %0d",
                        $time, rsp_protocol, rsp_payload_offset);
            end else begin
               want = walk_results.pop_front();
               check_field("transport_found", 32'(want.transport_found),
                           32'(rsp_transport_found));
               check_field("protocol", 32'(want.protocol), 32'(rsp_protocol));
               check_field("payload_offset", 32'(want.payload_offset),
                           32'(rsp_payload_offset));
               check_field("length_overflow", 32'(want.length_overflow),
                           32'(rsp_length_overflow));
            end
            recv_wait = recv_burst ? 0 : $urandom_range(0, MAX_IDLE_DRAW);
            if ($urandom_range(0, 9) == 0)
               recv_burst <= !recv_burst;
         end else if (rsp_valid && recv_wait != 0) begin
            recv_wait = recv_wait - 1;
         end
         rsp_stall <= (recv_wait != 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
         $display("ipv6_ext_header_walker test failed");
         $finish;
      end
   end

   task automatic wait_walker_idle();
      while (beat_q.size() != 0 || req_valid || walk_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_hop_limit(input logic [3:0] value);
      wait_walker_idle();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      hop_limit_cfg = value;
   endtask

   task automatic send_packet(input int n);
      beat_type bt;
      for (int i = 0; i < n; i++) begin
         bt.data_byte = pkt_bytes[i];
         bt.last = (i == n - 1);
         beat_q.push_back(bt);
      end
      bytes_sent += n;
      packets_sent++;
   endtask

   task automatic queue_noise(input int n);
      pkt_bytes.delete();
      repeat (n) pkt_bytes.push_back(8'($urandom_range(0, 255)));
      send_packet(n);
   endtask

   // fixed header, then one extension header per entry of chain_kinds but the
   // last, whose final entry is the type that ends the chain; cut 0 = whole
   task automatic queue_chain(input int len_lo, input int len_hi, input int tail_len,
                              input int cut);
      logic [7:0] len_byte;
      int         span;
      pkt_bytes.delete();
      repeat (FIXED_HEADER_BYTES) pkt_bytes.push_back(8'($urandom_range(0, 255)));
      pkt_bytes[NH_BYTE_INDEX] = chain_kinds[0];
      for (int i = 0; i < chain_kinds.size() - 1; i++) begin
         len_byte = 8'($urandom_range(len_lo, len_hi));
         span = (chain_kinds[i] == NH_AH) ? (int'(len_byte) + 2) * 4
                                          : (int'(len_byte) + 1) * 8;
         pkt_bytes.push_back(chain_kinds[i + 1]);
         pkt_bytes.push_back(len_byte);
         repeat (span - 2) pkt_bytes.push_back(8'($urandom_range(0, 255)));
      end
      repeat (tail_len) pkt_bytes.push_back(8'($urandom_range(0, 255)));
      // a cut past the built packet sends it whole
      send_packet((cut > 0 && cut < pkt_bytes.size()) ? cut : pkt_bytes.size());
   endtask

   function automatic logic [7:0] pick_ext_kind();
      case ($urandom_range(0, 3))
         0: return NH_HOP_BY_HOP;
         1: return NH_ROUTING;
         2: return NH_DEST_OPTS;
         default: return NH_AH;
      endcase
   endfunction

   function automatic logic [7:0] pick_terminal();
      case ($urandom_range(0, 11))
         0, 1: return NH_TCP;
         2, 3: return NH_UDP;
         4: return NH_ICMP;
         5: return NH_ICMPV6;
         6: return NH_FRAGMENT;
         7: return NH_ESP;
         8: return NH_NO_NEXT;
         9: return pick_ext_kind();
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic queue_random_packet();
      int kind;
      int n_ext;
      int len_hi;
      int tail;
      int cut;
      kind = $urandom_range(0, 99);
      if (kind < 85) begin
         n_ext = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 17) : $urandom_range(0, 4);
         len_hi = ($urandom_range(0, 7) == 0) ? 8 : 1;
         tail = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
         chain_kinds.delete();
         repeat (n_ext) chain_kinds.push_back(pick_ext_kind());
         chain_kinds.push_back(pick_terminal());
         // some chains get cut short somewhere inside
         cut = 0;
         if (kind >= 70)
            cut = $urandom_range(1, FIXED_HEADER_BYTES + n_ext * 16 + tail);
         queue_chain(0, len_hi, tail, cut);
      end else if (kind < 95) begin
         queue_noise($urandom_range(40, 90));
      end else begin
         queue_noise($urandom_range(1, FIXED_HEADER_BYTES - 1));
      end
   endtask

   task automatic run_random_phase(input int byte_target);
      int first_byte;
      int count;
      first_byte = bytes_sent;
      count = 0;
      while (bytes_sent - first_byte < byte_target || count < 8) begin
         // starve the sender now and then until every result is back
         if (count % 8 == 7)
            wait_walker_idle();
         queue_random_packet();
         count++;
      end
   endtask

   initial begin
      restart_walk();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed packets under the reset hop limit
      queue_noise(1);
      queue_noise(FIXED_HEADER_BYTES - 1);
      chain_kinds = '{NH_TCP};
      queue_chain(0, 0, 0, 0);
      chain_kinds = '{NH_NO_NEXT};
      queue_chain(0, 0, 0, 0);
      chain_kinds = '{NH_HOP_BY_HOP};
      queue_chain(0, 0, 0, 0);
      chain_kinds = '{NH_UDP};
      queue_chain(0, 0, 12, 0);
      chain_kinds = '{NH_HOP_BY_HOP, NH_ROUTING, NH_DEST_OPTS, NH_AH, NH_ICMPV6};
      queue_chain(0, 2, 6, 0);
      chain_kinds = '{NH_AH, NH_ICMP};
      queue_chain(0, 0, 3, 0);
      chain_kinds = '{NH_HOP_BY_HOP, NH_UDP};
      queue_chain(255, 255, 0, 0);
      chain_kinds = '{NH_ROUTING, NH_FRAGMENT};
      queue_chain(1, 1, 8, 0);
      chain_kinds = '{NH_DEST_OPTS, NH_ESP};
      queue_chain(0, 1, 8, 0);
      chain_kinds = '{NH_AH, NH_NO_NEXT};
      queue_chain(1, 1, 4, 0);
      chain_kinds = '{NH_HOP_BY_HOP, NH_UNKNOWN};
      queue_chain(0, 0, 5, 0);
      chain_kinds.delete();
      repeat (9) chain_kinds.push_back(NH_DEST_OPTS);
      chain_kinds.push_back(NH_TCP);
      queue_chain(0, 1, 4, 0);
      chain_kinds.delete();
      repeat (8) chain_kinds.push_back(NH_ROUTING);
      chain_kinds.push_back(NH_TCP);
      queue_chain(0, 0, 4, 0);
      // header cut short mid-body and right after its first byte
      chain_kinds = '{NH_HOP_BY_HOP, NH_TCP};
      queue_chain(3, 3, 0, 45);
      chain_kinds = '{NH_HOP_BY_HOP, NH_TCP};
      queue_chain(3, 3, 0, FIXED_HEADER_BYTES + 1);
      chain_kinds = '{NH_AH, NH_TCP};
      queue_chain(0, 0, 0, 0);
      chain_kinds = '{NH_ROUTING, NH_ESP};
      queue_chain(0, 0, 0, 0);

      program_hop_limit(4'd0);
      run_random_phase(300);
      program_hop_limit(4'd15);
      run_random_phase(300);

      // past the length limit: fifteen 2 KiB headers then TCP, then padding
      wait_walker_idle();
      steady_send = 1'b1;
      chain_kinds.delete();
      repeat (15) chain_kinds.push_back(($urandom_range(0, 1) == 0) ? NH_ROUTING
                                                                    : NH_HOP_BY_HOP);
      chain_kinds.push_back(NH_TCP);
      queue_chain(255, 255, OVERSIZE_BYTES - FIXED_HEADER_BYTES - 15 * 2048, 0);
      wait_walker_idle();
      steady_send = 1'b0;

      program_hop_limit(4'd1);
      run_random_phase(300);
      program_hop_limit(4'($urandom_range(2, 14)));
      run_random_phase(300);
      program_hop_limit(HOP_LIMIT_RESET);
      run_random_phase(300);
      program_hop_limit(4'($urandom_range(0, 15)));
      run_random_phase(200);
      wait_walker_idle();

      $display("walked %0d packets (%0d bytes) under hop limits 0, 1, 8, 15 and random ones",
               packets_sent, bytes_sent);
      $display("%0d results checked, one packet ran past the 64 KiB length limit",
               results_checked);
      if (mismatches == 0) begin
         $display("ipv6_ext_header_walker test passed");
      end else begin
         $display("ipv6_ext_header_walker test failed");
      end
      $finish;
   end

endmodule

### ipv6_ext_header_walker.f
hdl/iehw_pkg.sv
hdl/iehw_in_reg.sv
hdl/iehw_walk.sv
hdl/iehw_out_reg.sv
hdl/ipv6_ext_header_walker.sv
verif/tb_ipv6_ext_header_walker.sv
